// ----- design/iaalu_pkg.sv -----
// shared opcodes, command and status types for the integer operator unit
`default_nettype none
package iaalu_pkg;
  localparam logic [4:0] OP_EQ = 5'd0, OP_NE = 5'd1, OP_LT = 5'd2, OP_GT = 5'd3, OP_GE = 5'd4,
    OP_LE = 5'd5, OP_LAND = 5'd6, OP_LOR = 5'd7, OP_LXOR = 5'd8, OP_MUL = 5'd9, OP_DIV = 5'd10,
    OP_MOD = 5'd11, OP_ADD = 5'd12, OP_SUB = 5'd13, OP_AND = 5'd14, OP_OR = 5'd15,
    OP_XOR = 5'd16, OP_SHL = 5'd17, OP_LSR = 5'd18, OP_ASR = 5'd19, OP_POW = 5'd20,
    OP_LO = 5'd21, OP_HI = 5'd22, OP_BANK = 5'd23, OP_PLUS = 5'd24, OP_NEG = 5'd25,
    OP_INV = 5'd26, OP_NOT = 5'd27;
  localparam logic [1:0] KIND_SIMPLE = 2'd0, KIND_DIV = 2'd1, KIND_POW = 2'd2;
  localparam int NARROW_BITS = 16;
  localparam int BYTE_BITS = 8;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       last;
  } status_t;
endpackage
`default_nettype wire

// ----- design/assembler_integer_operator_alu.sv -----
// top level of the assembler integer operator unit
// channel | direction | handshake          | payload
// input   | in        | in_valid/in_stall  | op, left_operand, right_operand
// output  | out       | out_valid/out_stall| value, div_by_zero
// config  | in        | apb write          | narrow_mode at byte address 0
// simple operators register their result in the load state and present it in the output state
// div, mod and non-negative pow go from the load state to the run state, where the
// one-bit-per-step divider and square-and-multiply loop iterate, and then to the output state
// a new transaction is taken in the cycle the previous result leaves
// rst_ni clears the controller and narrow_mode; a stalled result holds
`default_nettype none
module assembler_integer_operator_alu #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic                 paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [4:0]           op_i,
  input  wire logic [WORD_BITS-1:0] left_operand_i,
  input  wire logic [WORD_BITS-1:0] right_operand_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [WORD_BITS-1:0]      value_o,
  output logic                      div_by_zero_o
);
  logic narrow_mode_q;
  iaalu_pkg::cmd_t    cmd;
  iaalu_pkg::status_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {31'd0, narrow_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      narrow_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      narrow_mode_q <= pwdata[0];
    end
  end

  iaalu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  iaalu_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk_i, .narrow_mode_i(narrow_mode_q), .op_i, .left_operand_i, .right_operand_i,
    .cmd_i(cmd), .sts_o(sts), .value_o, .div_by_zero_o
  );
endmodule
`default_nettype wire

// ----- design/iaalu_ctrl.sv -----
// controller state machine sequencing load, iterations and result hand-off
`default_nettype none
module iaalu_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire iaalu_pkg::status_t sts_i,
  output iaalu_pkg::cmd_t        cmd_o
);
  localparam logic [1:0] ST_IDLE = 2'd0, ST_LOAD = 2'd1, ST_RUN = 2'd2, ST_OUT = 2'd3;
  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.kind == iaalu_pkg::KIND_SIMPLE) begin
          cmd_o.finish = 1'b1;
          state_d = ST_OUT;
        end else begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          cmd_o.finish = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: if (!out_stall_i) begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o  = !((state_q == ST_IDLE) || (state_q == ST_OUT && !out_stall_i));
  assign out_valid_o = (state_q == ST_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// ----- design/iaalu_dp.sv -----
// datapath: operand registers, restoring divider, square-and-multiply unit, result register
`default_nettype none
module iaalu_dp #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  narrow_mode_i,
  input  wire logic [4:0]            op_i,
  input  wire logic [WORD_BITS-1:0]  left_operand_i,
  input  wire logic [WORD_BITS-1:0]  right_operand_i,
  input  wire iaalu_pkg::cmd_t       cmd_i,
  output iaalu_pkg::status_t         sts_o,
  output logic [WORD_BITS-1:0]       value_o,
  output logic                       div_by_zero_o
);
  localparam int CW = $clog2(WORD_BITS + 1);
  localparam logic [WORD_BITS-1:0] SAT_POS = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] NARROW_MASK = WORD_BITS'({iaalu_pkg::NARROW_BITS{1'b1}});
  localparam logic [WORD_BITS-1:0] BYTE_MASK = WORD_BITS'({iaalu_pkg::BYTE_BITS{1'b1}});

  logic [4:0]           op_q;
  logic                 nar_q;
  logic [WORD_BITS-1:0] a_q, b_q;
  logic [WORD_BITS-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [WORD_BITS-1:0] acc_q, acc_d, base_q, base_d, exp_q, exp_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [WORD_BITS-1:0] res_q, res_d;
  logic                 dz_q, dz_d;

  logic narrow_op, is_div, is_pow, na, nb;
  logic [WORD_BITS-1:0] x, y, sa_mag, sb_mag, simple_r, rem_sh;
  logic [WORD_BITS:0]   trial;

  assign na = a_q[WORD_BITS-1];
  assign nb = b_q[WORD_BITS-1];
  assign narrow_op = (op_q == iaalu_pkg::OP_MUL) || (op_q == iaalu_pkg::OP_DIV) ||
                     (op_q >= iaalu_pkg::OP_ADD && op_q <= iaalu_pkg::OP_XOR);
  assign is_div = (op_q == iaalu_pkg::OP_DIV) || (op_q == iaalu_pkg::OP_MOD);
  assign is_pow = (op_q == iaalu_pkg::OP_POW) && !nb;
  assign x = a_q & NARROW_MASK;
  assign y = b_q & NARROW_MASK;
  assign sa_mag = (nar_q && narrow_op) ? x : (na ? (~a_q + 1'b1) : a_q);
  assign sb_mag = (nar_q && narrow_op) ? y : (nb ? (~b_q + 1'b1) : b_q);

  // shift helper for the simple operators
  function automatic logic [WORD_BITS-1:0] shift_op(input logic [4:0] op,
      input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b);
    logic neg, big;
    logic [WORD_BITS-1:0] mag, v, r;
    neg = b[WORD_BITS-1];
    mag = neg ? (~b + 1'b1) : b;
    big = (mag >= WORD_BITS'(WORD_BITS)) || (neg && mag == {1'b1, {(WORD_BITS-1){1'b0}}});
    v = (op == iaalu_pkg::OP_ASR && a[WORD_BITS-1]) ? ~a : a;
    if (big) begin
      r = '0;
    end else if ((op == iaalu_pkg::OP_SHL) ? !neg : neg) begin
      r = v << mag;
    end else begin
      r = v >> mag;
    end
    if (op == iaalu_pkg::OP_ASR) begin
      if (!neg && big) r = {WORD_BITS{a[WORD_BITS-1]}};
      else if (a[WORD_BITS-1] && !(neg && big)) r = ~r;
    end
    return r;
  endfunction

  always_comb begin
    simple_r = '0;
    if (nar_q && narrow_op) begin
      unique case (op_q)
        iaalu_pkg::OP_MUL: simple_r = (x * y) & NARROW_MASK;
        iaalu_pkg::OP_ADD: simple_r = (x + y) & NARROW_MASK;
        iaalu_pkg::OP_SUB: simple_r = (x - y) & NARROW_MASK;
        iaalu_pkg::OP_AND: simple_r = x & y;
        iaalu_pkg::OP_OR:  simple_r = x | y;
        default:           simple_r = x ^ y;
      endcase
    end else begin
      unique case (op_q)
        iaalu_pkg::OP_EQ:   simple_r = WORD_BITS'(a_q == b_q);
        iaalu_pkg::OP_NE:   simple_r = WORD_BITS'(a_q != b_q);
        iaalu_pkg::OP_LT:   simple_r = WORD_BITS'($signed(a_q) < $signed(b_q));
        iaalu_pkg::OP_GT:   simple_r = WORD_BITS'($signed(a_q) > $signed(b_q));
        iaalu_pkg::OP_GE:   simple_r = WORD_BITS'($signed(a_q) >= $signed(b_q));
        iaalu_pkg::OP_LE:   simple_r = WORD_BITS'($signed(a_q) <= $signed(b_q));
        iaalu_pkg::OP_LAND: simple_r = WORD_BITS'(a_q != '0 && b_q != '0);
        iaalu_pkg::OP_LOR:  simple_r = WORD_BITS'(a_q != '0 || b_q != '0);
        iaalu_pkg::OP_LXOR: simple_r = WORD_BITS'((a_q == '0) != (b_q == '0));
        iaalu_pkg::OP_MUL:  simple_r = a_q * b_q;
        iaalu_pkg::OP_ADD:  simple_r = a_q + b_q;
        iaalu_pkg::OP_SUB:  simple_r = a_q - b_q;
        iaalu_pkg::OP_AND:  simple_r = a_q & b_q;
        iaalu_pkg::OP_OR:   simple_r = a_q | b_q;
        iaalu_pkg::OP_XOR:  simple_r = a_q ^ b_q;
        iaalu_pkg::OP_SHL, iaalu_pkg::OP_LSR, iaalu_pkg::OP_ASR:
          simple_r = shift_op(op_q, a_q, b_q);
        iaalu_pkg::OP_LO:   simple_r = b_q & BYTE_MASK;
        iaalu_pkg::OP_HI:   simple_r = (b_q >> iaalu_pkg::BYTE_BITS) & BYTE_MASK;
        iaalu_pkg::OP_BANK: simple_r = (b_q >> iaalu_pkg::NARROW_BITS) & BYTE_MASK;
        iaalu_pkg::OP_PLUS: simple_r = b_q;
        iaalu_pkg::OP_NEG:  simple_r = ~b_q + 1'b1;
        iaalu_pkg::OP_INV:  simple_r = ~b_q;
        iaalu_pkg::OP_NOT:  simple_r = WORD_BITS'(b_q == '0);
        default:            simple_r = '0;
      endcase
    end
  end

  // restoring division, one quotient bit per step
  assign rem_sh = {rem_q[WORD_BITS-2:0], quo_q[WORD_BITS-1]};
  assign trial  = {rem_q, quo_q[WORD_BITS-1]} - {1'b0, dvs_q};

  always_comb begin
    sts_o.kind = is_div ? iaalu_pkg::KIND_DIV :
                 is_pow ? iaalu_pkg::KIND_POW : iaalu_pkg::KIND_SIMPLE;
    sts_o.last = (cnt_q == CW'(1));
  end

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q;
    acc_d = acc_q; base_d = base_q; exp_d = exp_q; cnt_d = cnt_q;
    res_d = res_q; dz_d = dz_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end else if (cmd_i.step) begin
      cnt_d = cnt_q - 1'b1;
      if (trial[WORD_BITS]) begin
        rem_d = rem_sh;
        quo_d = {quo_q[WORD_BITS-2:0], 1'b0};
      end else begin
        rem_d = trial[WORD_BITS-1:0];
        quo_d = {quo_q[WORD_BITS-2:0], 1'b1};
      end
      if (exp_q[0]) acc_d = acc_q * base_q;
      base_d = base_q * base_q;
      exp_d = exp_q >> 1;
    end else if (cnt_q == '0) begin
      // counter at zero with no load or step, as in the controller's load state: prime the iterative units
      quo_d = sa_mag; rem_d = '0; dvs_d = sb_mag;
      acc_d = WORD_BITS'(1); base_d = a_q; exp_d = b_q;
      cnt_d = CW'(WORD_BITS);
    end
    if (cmd_i.finish) begin
      dz_d = 1'b0;
      if (is_div) begin
        if (sb_mag == '0) begin
          res_d = (nar_q && narrow_op) ? NARROW_MASK : SAT_POS;
          dz_d = 1'b1;
        end else if (op_q == iaalu_pkg::OP_DIV) begin
          res_d = (!(nar_q && narrow_op) && na != nb) ? (~quo_d + 1'b1) : quo_d;
        end else begin
          res_d = na ? (~rem_d + 1'b1) : rem_d;
        end
      end else if (is_pow) begin
        res_d = acc_d;
      end else if (op_q == iaalu_pkg::OP_POW) begin
        res_d = (a_q == '0) ? SAT_POS : '0;
        dz_d = (a_q == '0);
      end else begin
        res_d = simple_r;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i; a_q <= left_operand_i; b_q <= right_operand_i; nar_q <= narrow_mode_i;
    end
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
    acc_q <= acc_d; base_q <= base_d; exp_q <= exp_d; cnt_q <= cnt_d;
    res_q <= res_d; dz_q <= dz_d;
  end

  assign value_o = res_q;
  assign div_by_zero_o = dz_q;
endmodule
`default_nettype wire

// ----- design/iaalu_checker.sv -----
// port-level checker for the integer operator unit and its bind
`default_nettype none
module iaalu_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic div_by_zero_o,
  input wire logic pready
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(div_by_zero_o)) else $error("result");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o) else $error("accept");
  a_out_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o) else $error("stall");
  a_ready: assert property (@(posedge clk_i) pready) else $error("pready");
endmodule

bind assembler_integer_operator_alu iaalu_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .div_by_zero_o, .pready
);
`default_nettype wire

// ----- test/tb_assembler_integer_operator_alu.sv -----
// testbench for the assembler integer operator unit: directed and random operator checks
`timescale 1ns / 100ps
module tb_assembler_integer_operator_alu;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [4:0]  op_i = '0;
  logic [31:0] left_operand_i = '0, right_operand_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] value_o;
  logic        div_by_zero_o;

  typedef struct packed {
    logic [31:0] value;
    logic        dbz;
  } alu_result_t;

  alu_result_t expected_results[$];
  logic        narrow_sel = 1'b0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  localparam int CYCLE_LIMIT = 1000000;

  assembler_integer_operator_alu uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] shift_l(logic [31:0] x, int n);
    return (n >= 32) ? 32'd0 : x << n;
  endfunction

  function automatic logic [31:0] shift_r(logic [31:0] x, int n);
    return (n >= 32) ? 32'd0 : x >> n;
  endfunction

  function automatic alu_result_t evaluate_operator(logic [4:0] op, logic [31:0] a,
                                                    logic [31:0] b, logic narrow);
    alu_result_t res;
    logic signed [31:0] sa, sb;
    logic [15:0] x, y;
    logic [31:0] ma, mb, base, e;
    sa = a;
    sb = b;
    x = a[15:0];
    y = b[15:0];
    res = '0;
    if (narrow && (op == iaalu_pkg::OP_MUL || op == iaalu_pkg::OP_DIV ||
                   (op >= iaalu_pkg::OP_ADD && op <= iaalu_pkg::OP_XOR))) begin
      case (op)
        iaalu_pkg::OP_MUL: res.value = {16'd0, 16'(x * y)};
        iaalu_pkg::OP_DIV: begin
          if (y == 0) begin
            res.value = 32'hffff;
            res.dbz = 1'b1;
          end else begin
            res.value = {16'd0, x / y};
          end
        end
        iaalu_pkg::OP_ADD: res.value = {16'd0, 16'(x + y)};
        iaalu_pkg::OP_SUB: res.value = {16'd0, 16'(x - y)};
        iaalu_pkg::OP_AND: res.value = {16'd0, x & y};
        iaalu_pkg::OP_OR:  res.value = {16'd0, x | y};
        default: res.value = {16'd0, x ^ y};
      endcase
      return res;
    end
    case (op)
      iaalu_pkg::OP_EQ:   res.value = 32'(a == b);
      iaalu_pkg::OP_NE:   res.value = 32'(a != b);
      iaalu_pkg::OP_LT:   res.value = 32'(sa < sb);
      iaalu_pkg::OP_GT:   res.value = 32'(sa > sb);
      iaalu_pkg::OP_GE:   res.value = 32'(sa >= sb);
      iaalu_pkg::OP_LE:   res.value = 32'(sa <= sb);
      iaalu_pkg::OP_LAND: res.value = 32'(a != 0 && b != 0);
      iaalu_pkg::OP_LOR:  res.value = 32'(a != 0 || b != 0);
      iaalu_pkg::OP_LXOR: res.value = 32'((a == 0) != (b == 0));
      iaalu_pkg::OP_MUL:  res.value = a * b;
      iaalu_pkg::OP_DIV, iaalu_pkg::OP_MOD: begin
        if (b == 0) begin
          res.value = 32'h7fffffff;
          res.dbz = 1'b1;
        end else begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          if (op == iaalu_pkg::OP_DIV) begin
            res.value = ma / mb;
            if (a[31] != b[31]) res.value = -res.value;
          end else begin
            res.value = ma % mb;
            if (a[31]) res.value = -res.value;
          end
        end
      end
      iaalu_pkg::OP_ADD: res.value = a + b;
      iaalu_pkg::OP_SUB: res.value = a - b;
      iaalu_pkg::OP_AND: res.value = a & b;
      iaalu_pkg::OP_OR:  res.value = a | b;
      iaalu_pkg::OP_XOR: res.value = a ^ b;
      iaalu_pkg::OP_SHL: begin
        if (sb >= 32 || sb <= -32) res.value = 0;
        else res.value = (sb > 0) ? shift_l(a, sb) : shift_r(a, -sb);
      end
      iaalu_pkg::OP_LSR: begin
        if (sb >= 32 || sb <= -32) res.value = 0;
        else res.value = (sb > 0) ? shift_r(a, sb) : shift_l(a, -sb);
      end
      iaalu_pkg::OP_ASR: begin
        if (sb >= 32) res.value = a[31] ? 32'hffffffff : 32'd0;
        else if (sb <= -32) res.value = 0;
        else if (!a[31]) res.value = (sb > 0) ? shift_r(a, sb) : shift_l(a, -sb);
        else res.value = ~((sb > 0) ? shift_r(~a, sb) : shift_l(~a, -sb));
      end
      iaalu_pkg::OP_POW: begin
        if (b[31]) begin
          if (a == 0) begin
            res.value = 32'h7fffffff;
            res.dbz = 1'b1;
          end
        end else begin
          base = a;
          e = b;
          res.value = 1;
          while (e != 0) begin
            if (e[0]) res.value = res.value * base;
            base = base * base;
            e = e >> 1;
          end
        end
      end
      iaalu_pkg::OP_LO:   res.value = {24'd0, b[7:0]};
      iaalu_pkg::OP_HI:   res.value = {24'd0, b[15:8]};
      iaalu_pkg::OP_BANK: res.value = {24'd0, b[23:16]};
      iaalu_pkg::OP_PLUS: res.value = b;
      iaalu_pkg::OP_NEG:  res.value = -b;
      iaalu_pkg::OP_INV:  res.value = ~b;
      iaalu_pkg::OP_NOT:  res.value = 32'(b == 0);
      default: res.value = 0;
    endcase
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_assembler_integer_operator_alu: errors");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    case (cycle_count[11:10])
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected transaction value %h dbz %b", $time, value_o,
                 div_by_zero_o);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (value_o !== exp_r.value) begin
          $display("%0t value mismatch: expected %h actual %h", $time, exp_r.value, value_o);
          error_count++;
        end
        if (div_by_zero_o !== exp_r.dbz) begin
          $display("%0t div_by_zero mismatch: expected %b actual %b", $time, exp_r.dbz,
                   div_by_zero_o);
          error_count++;
        end
      end
    end
  end

  task automatic apb_write(logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 1'b0;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    narrow_sel = data[0];
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_narrow(logic [31:0] data);
    wait_drained();
    apb_write(data);
  endtask

  task automatic send_operation(logic [4:0] op, logic [31:0] a, logic [31:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    op_i <= op;
    left_operand_i <= a;
    right_operand_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(evaluate_operator(op, a, b, narrow_sel));
  endtask

  task automatic idle_input();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'(int'($urandom_range(0, 80)) - 40);
      3: return 32'd0;
      4: return 32'hffffffff;
      5: return {16'd0, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_wide();
    send_operation(iaalu_pkg::OP_DIV, 32'h80000000, 32'hffffffff);
    send_operation(iaalu_pkg::OP_MOD, 32'h80000000, 32'hffffffff);
    send_operation(iaalu_pkg::OP_DIV, 32'd5, 32'd0);
    send_operation(iaalu_pkg::OP_MOD, 32'hfffffff9, 32'd2);
    send_operation(iaalu_pkg::OP_DIV, 32'hfffffff9, 32'd2);
    send_operation(iaalu_pkg::OP_POW, 32'd0, 32'hffffffff);
    send_operation(iaalu_pkg::OP_POW, 32'd3, 32'hfffffffe);
    send_operation(iaalu_pkg::OP_POW, 32'd0, 32'd0);
    send_operation(iaalu_pkg::OP_POW, 32'd3, 32'h7fffffff);
    send_operation(iaalu_pkg::OP_ASR, 32'h80000000, 32'd32);
    send_operation(iaalu_pkg::OP_ASR, 32'h80000001, 32'hffffffe0);
    send_operation(iaalu_pkg::OP_ASR, 32'hf0000000, 32'hfffffffc);
    send_operation(iaalu_pkg::OP_ASR, 32'h70000000, 32'd31);
    send_operation(iaalu_pkg::OP_SHL, 32'hffffffff, 32'd31);
    send_operation(iaalu_pkg::OP_SHL, 32'hffffffff, 32'hffffffe1);
    send_operation(iaalu_pkg::OP_LSR, 32'hffffffff, 32'd32);
    send_operation(iaalu_pkg::OP_LSR, 32'hffffffff, 32'hfffffffc);
    send_operation(iaalu_pkg::OP_BANK, 32'd0, 32'h12345678);
    send_operation(iaalu_pkg::OP_HI, 32'd0, 32'h12345678);
    for (int i = 0; i < 32; i++) send_operation(5'(i), 32'h80000000, 32'h7fffffff);
    idle_input();
  endtask

  task automatic test_directed_narrow();
    set_narrow(32'd1);
    send_operation(iaalu_pkg::OP_DIV, 32'h12340005, 32'hffff0000);
    send_operation(iaalu_pkg::OP_MUL, 32'hffffffff, 32'hffffffff);
    send_operation(iaalu_pkg::OP_SUB, 32'd0, 32'd1);
    send_operation(iaalu_pkg::OP_ADD, 32'hffff, 32'd1);
    send_operation(iaalu_pkg::OP_MOD, 32'd7, 32'd0);
    idle_input();
  endtask

  task automatic test_random(int count);
    logic [4:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(28, 31))
                                        : 5'($urandom_range(0, 27));
      send_operation(op, random_operand(), random_operand());
    end
    idle_input();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_wide();
    test_directed_narrow();
    test_random(500);
    set_narrow(32'hfffffffe);
    test_random(500);
    set_narrow(32'hffffffff);
    test_random(450);
    set_narrow(32'd0);
    test_random(450);
    wait_drained();
    if (error_count == 0) $display("tb_assembler_integer_operator_alu: clean");
    else $display("tb_assembler_integer_operator_alu: errors");
    $finish;
  end
endmodule

// ----- sim.f -----
design/iaalu_pkg.sv
design/iaalu_ctrl.sv
design/iaalu_dp.sv
design/assembler_integer_operator_alu.sv
design/iaalu_checker.sv
test/tb_assembler_integer_operator_alu.sv
